[rtl/counting_semaphore_table_assert.svh]
// Assertion macros used by the semaphore table top level.
// No dependencies; include by bare file name inside a module body.
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cst_pkg.sv]
// Types and codes for the counting semaphore table.
// No dependencies; used by the front end, back end and top level.
package cst_pkg;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_POST    = 2'd2,
        ACT_WAIT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_NOT_INIT = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        action_t     action;
        logic        bad_id;
        logic [7:0]  slot;
        logic [31:0] init_value;
        logic [15:0] pid;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic        must_block;
        logic        woken_valid;
        logic [15:0] woken_pid;
    } res_t;

endpackage

[rtl/cst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/cst_front.sv]
// Front end: checks the semaphore id, masks the pid and holds requests in a
// two-entry queue for the back end. Depends on cst_pkg.
module cst_front #(
    parameter int NUM_SEMS = 16,
    parameter int PID_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    action,
    input  logic [7:0]    sem_id,
    input  logic [31:0]   init_value,
    input  logic [15:0]   caller_pid,
    output logic          cmd_valid,
    output cst_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import cst_pkg::*;

    localparam int STORE_W = (PID_BITS < 16) ? PID_BITS : 16;

    cmd_t       entry0_reg, entry0_next;
    cmd_t       entry1_reg, entry1_next;
    logic [1:0] count_reg, count_next;
    cmd_t       new_cmd;
    logic       push;

    always_comb
    begin
        new_cmd.action     = action_t'(action);
        new_cmd.bad_id     = (sem_id == 8'd0) || (sem_id > 8'(NUM_SEMS));
        new_cmd.slot       = sem_id - 8'd1;
        new_cmd.init_value = init_value;
        new_cmd.pid        = 16'(caller_pid[STORE_W-1:0]);
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry0_reg;

    always_comb
    begin
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
        if (cmd_pop)
        begin
            // shift the older entry forward, or take the new request directly
            if (count_reg == 2'd2)
            begin
                entry0_next = entry1_reg;
            end
            else if (push)
            begin
                entry0_next = new_cmd;
            end
            if (push && count_reg == 2'd2)
            begin
                entry1_next = new_cmd;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                entry0_next = new_cmd;
            end
            else
            begin
                entry1_next = new_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

endmodule

[rtl/cst_back.sv]
// Back end: read-modify-write sequencer over the semaphore entry memory and
// the waiter memory. Depends on cst_pkg and cst_ram.
module cst_back #(
    parameter int NUM_SEMS    = 16,
    parameter int MAX_WAITERS = 16,
    parameter int PID_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cst_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          out_free,
    output logic          res_valid,
    output cst_pkg::res_t res
);
    import cst_pkg::*;

    localparam int STORE_W = (PID_BITS < 16) ? PID_BITS : 16;
    localparam int SW      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QW      = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int FW      = $clog2(MAX_WAITERS + 1);
    localparam int WDEPTH  = NUM_SEMS * MAX_WAITERS;
    localparam int WA      = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int MW      = 32 + 2 * QW + FW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAKE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [NUM_SEMS-1:0] in_use_reg, in_use_next;

    logic               meta_we;
    logic [MW-1:0]      meta_wdata;
    logic [MW-1:0]      meta_rdata;
    logic [SW-1:0]      slot;
    logic [31:0]        cnt;
    logic [QW-1:0]      head;
    logic [QW-1:0]      tail;
    logic [FW-1:0]      fill;
    logic [QW-1:0]      head_inc;
    logic [QW-1:0]      tail_inc;
    logic [WA-1:0]      waiter_base;
    logic               waiter_we;
    logic               waiter_re;
    logic [WA-1:0]      waiter_waddr;
    logic [WA-1:0]      waiter_raddr;
    logic [STORE_W-1:0] waiter_rdata;

    assign slot        = cmd_reg.slot[SW-1:0];
    assign cnt         = meta_rdata[MW-1 -: 32];
    assign head        = meta_rdata[FW + 2*QW - 1 -: QW];
    assign tail        = meta_rdata[FW + QW - 1 -: QW];
    assign fill        = meta_rdata[FW-1:0];
    assign head_inc    = (head == QW'(MAX_WAITERS - 1)) ? '0 : head + QW'(1);
    assign tail_inc    = (tail == QW'(MAX_WAITERS - 1)) ? '0 : tail + QW'(1);
    assign waiter_base = WA'(slot) * WA'(MAX_WAITERS);
    assign waiter_waddr = waiter_base + WA'(tail);
    assign waiter_raddr = waiter_base + WA'(head);

    // one entry per semaphore: count, head, tail, fill
    cst_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_SEMS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot),
        .wdata (meta_wdata),
        .re    (state_reg == S_IDLE),
        .raddr (cmd.slot[SW-1:0]),
        .rdata (meta_rdata)
    );

    cst_ram #(
        .WIDTH (STORE_W),
        .DEPTH (WDEPTH)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (waiter_we),
        .waddr (waiter_waddr),
        .wdata (cmd_reg.pid[STORE_W-1:0]),
        .re    (waiter_re),
        .raddr (waiter_raddr),
        .rdata (waiter_rdata)
    );

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next  = state_reg;
        in_use_next = in_use_reg;
        meta_we     = 1'b0;
        meta_wdata  = meta_rdata;
        waiter_we   = 1'b0;
        waiter_re   = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        res.status  = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    res_valid  = 1'b1;
                    if (cmd_reg.bad_id)
                    begin
                        res.status = ST_BAD_ID;
                    end
                    else if (cmd_reg.action == ACT_INIT)
                    begin
                        if (!in_use_reg[slot])
                        begin
                            in_use_next[slot] = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {cmd_reg.init_value, {(2*QW + FW){1'b0}}};
                        end
                    end
                    else if (!in_use_reg[slot])
                    begin
                        res.status = ST_NOT_INIT;
                    end
                    else
                    begin
                        case (cmd_reg.action)
                            ACT_DESTROY:
                            begin
                                // init rewrites the whole entry, so only drop the slot
                                in_use_next[slot] = 1'b0;
                            end
                            ACT_POST:
                            begin
                                if (fill != '0)
                                begin
                                    // hand the unit to the oldest waiter
                                    meta_we    = 1'b1;
                                    meta_wdata = {cnt, head_inc, tail, fill - FW'(1)};
                                    waiter_re  = 1'b1;
                                    res_valid  = 1'b0;
                                    state_next = S_WAKE;
                                end
                                else if (cnt != 32'hFFFF_FFFF)
                                begin
                                    meta_we    = 1'b1;
                                    meta_wdata = {cnt + 32'd1, head, tail, fill};
                                end
                            end
                            ACT_WAIT:
                            begin
                                if (cnt != 32'd0)
                                begin
                                    meta_we    = 1'b1;
                                    meta_wdata = {cnt - 32'd1, head, tail, fill};
                                end
                                else if (fill == FW'(MAX_WAITERS))
                                begin
                                    res.status = ST_FULL;
                                end
                                else
                                begin
                                    meta_we        = 1'b1;
                                    meta_wdata     = {cnt, head, tail_inc, fill + FW'(1)};
                                    waiter_we      = 1'b1;
                                    res.must_block = 1'b1;
                                end
                            end
                            default:
                            begin
                                res.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    res_valid       = 1'b1;
                    res.woken_valid = 1'b1;
                    res.woken_pid   = 16'(waiter_rdata);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

endmodule

[rtl/counting_semaphore_table.sv]
// Counting semaphore table with a FIFO of blocked pids per semaphore.
//
// Input channel (in_valid/in_ready): one request per item: action, sem_id,
// init_value, caller_pid. Output channel (out_valid/out_ready): exactly one
// result per request, in request order: status, must_block, woken_valid,
// woken_pid.
// A two-entry request queue decouples the id check from the execution
// sequencer. The sequencer reads the semaphore entry memory in its idle
// state and updates it in its exec state; a post that releases a waiter adds
// a wake state for the waiter memory read. It takes a new request only once
// it is back in idle.
// Requests keep being accepted while a result waits in the output register;
// if the receiver holds out_ready low, the sequencer stalls on its finished
// result and the queue fills, then in_ready drops.
// Reset (rst_n, asynchronous, active low) empties the queue and output
// register and frees every slot; no memory clearing pass is needed, so the
// block is ready as soon as reset is released.
// Depends on cst_pkg, cst_front, cst_back, cst_ram and the assertion header.
module counting_semaphore_table #(
    parameter int NUM_SEMS    = 16,
    parameter int MAX_WAITERS = 16,
    parameter int PID_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  sem_id,
    input  logic [31:0] init_value,
    input  logic [15:0] caller_pid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        must_block,
    output logic        woken_valid,
    output logic [15:0] woken_pid
);
    import cst_pkg::*;

    `include "counting_semaphore_table_assert.svh"

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic out_free;
    logic res_valid;
    res_t res;
    logic out_valid_reg;
    res_t res_reg;

    cst_front #(
        .NUM_SEMS (NUM_SEMS),
        .PID_BITS (PID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sem_id     (sem_id),
        .init_value (init_value),
        .caller_pid (caller_pid),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    cst_back #(
        .NUM_SEMS    (NUM_SEMS),
        .MAX_WAITERS (MAX_WAITERS),
        .PID_BITS    (PID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign must_block  = res_reg.must_block;
    assign woken_valid = res_reg.woken_valid;
    assign woken_pid   = res_reg.woken_pid;

    `CST_ASSERT_IMPL(a_no_overwrite, clk, rst_n, res_valid, out_free,
        "result overwrote a pending result")
    `CST_ASSERT_IMPL(a_block_xor_wake, clk, rst_n, out_valid, !(must_block && woken_valid),
        "must_block and woken_valid together")
    `CST_ASSERT_IMPL(a_error_clean, clk, rst_n, out_valid && status != ST_OK,
        !must_block && !woken_valid, "error result carries a side effect")
    `CST_ASSERT_IMPL(a_pid_zero, clk, rst_n, out_valid && !woken_valid, woken_pid == 16'd0,
        "woken_pid nonzero without a wake")

endmodule

[tb/sv/tb_counting_semaphore_table.sv]
// Self-checking testbench for counting_semaphore_table: a directed table, then
// random request streams, each result checked against the table's expectation or an in-bench predictor.
// Depends on cst_pkg and the counting_semaphore_table RTL.
`timescale 1ns / 100ps

module tb_counting_semaphore_table;
    import cst_pkg::*;

    localparam int NUM_SEMS     = 16;
    localparam int MAX_WAITERS  = 16;
    localparam int PID_BITS     = 16;
    localparam logic [15:0] PID_MASK = (PID_BITS >= 16) ? 16'hFFFF
                                                        : 16'((1 << PID_BITS) - 1);
    localparam int RANDOM_ITEMS = 1324;
    localparam int BLOCK_LEN    = 40;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        action_t     act;
        logic [7:0]  id;
        logic [31:0] val;
        logic [15:0] pid;
    } sem_req_t;

    typedef struct {
        sem_req_t req;
        int       reps;
        bit       typed;
        res_t     want;
    } dir_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  action     = '0;
    logic [7:0]  sem_id     = '0;
    logic [31:0] init_value = '0;
    logic [15:0] caller_pid = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  status;
    logic        must_block;
    logic        woken_valid;
    logic [15:0] woken_pid;

    // Predictor state
    bit          sem_busy   [NUM_SEMS];
    logic [31:0] sem_units  [NUM_SEMS];
    logic [15:0] waiter_pid [NUM_SEMS][MAX_WAITERS];
    int          wq_head    [NUM_SEMS];
    int          wq_tail    [NUM_SEMS];
    int          wq_fill    [NUM_SEMS];

    res_t     pending_results[$];
    dir_row_t directed_rows[$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       stuck_cycles = 0;
    bit       calm         = 1'b0;

    counting_semaphore_table #(
        .NUM_SEMS   (NUM_SEMS),
        .MAX_WAITERS(MAX_WAITERS),
        .PID_BITS   (PID_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sem_id     (sem_id),
        .init_value (init_value),
        .caller_pid (caller_pid),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .must_block (must_block),
        .woken_valid(woken_valid),
        .woken_pid  (woken_pid)
    );

    always #5 clk = ~clk;

    function automatic res_t sem_apply(input sem_req_t r);
        res_t res;
        int   s;
        res = '0;
        res.status = ST_OK;
        if (r.id == 8'd0 || r.id > NUM_SEMS)
        begin
            res.status = ST_BAD_ID;
        end
        else
        begin
            s = int'(r.id) - 1;
            if (r.act == ACT_INIT)
            begin
                // claim only a free slot; a slot in use keeps count and queue
                if (!sem_busy[s])
                begin
                    sem_busy[s]  = 1'b1;
                    sem_units[s] = r.val;
                    wq_head[s]   = 0;
                    wq_tail[s]   = 0;
                    wq_fill[s]   = 0;
                end
            end
            else if (!sem_busy[s])
            begin
                res.status = ST_NOT_INIT;
            end
            else
            begin
                case (r.act)
                    ACT_DESTROY:
                    begin
                        sem_busy[s]  = 1'b0;
                        sem_units[s] = '0;
                        wq_head[s]   = 0;
                        wq_tail[s]   = 0;
                        wq_fill[s]   = 0;
                    end
                    ACT_POST:
                    begin
                        if (wq_fill[s] > 0)
                        begin
                            res.woken_valid = 1'b1;
                            res.woken_pid   = waiter_pid[s][wq_head[s]];
                            wq_head[s] = (wq_head[s] + 1) % MAX_WAITERS;
                            wq_fill[s]--;
                        end
                        else if (sem_units[s] != 32'hFFFF_FFFF)
                        begin
                            sem_units[s]++;
                        end
                    end
                    default:
                    begin
                        if (sem_units[s] != 32'd0)
                        begin
                            sem_units[s]--;
                        end
                        else if (wq_fill[s] >= MAX_WAITERS)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            waiter_pid[s][wq_tail[s]] = r.pid & PID_MASK;
                            wq_tail[s] = (wq_tail[s] + 1) % MAX_WAITERS;
                            wq_fill[s]++;
                            res.must_block = 1'b1;
                        end
                    end
                endcase
            end
        end
        return res;
    endfunction

    // Mostly zero, some short, a few long.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // bias: 0 balanced, 1 wait heavy, 2 post heavy; focus narrows valid ids to 1..4
    function automatic sem_req_t random_request(input int bias, input bit focus);
        sem_req_t r;
        int       pick;
        int       w_init;
        int       w_destroy;
        int       w_post;
        w_init    = 8;
        w_destroy = 2;
        w_post    = (bias == 1) ? 25 : (bias == 2) ? 65 : 42;
        if (bias == 0)
        begin
            w_init    = 10;
            w_destroy = 5;
        end
        pick = $urandom_range(99);
        if (pick < w_init)
            r.act = ACT_INIT;
        else if (pick < w_init + w_destroy)
            r.act = ACT_DESTROY;
        else if (pick < w_init + w_destroy + w_post)
            r.act = ACT_POST;
        else
            r.act = ACT_WAIT;

        pick = $urandom_range(99);
        if (pick < 2)
            r.id = 8'd0;
        else if (pick < 6)
            r.id = 8'($urandom_range(255, NUM_SEMS + 1));
        else if (focus)
            r.id = 8'($urandom_range(4, 1));
        else
            r.id = 8'($urandom_range(NUM_SEMS, 1));

        pick = $urandom_range(9);
        if (pick < 5)
            r.val = 32'($urandom_range(3));
        else if (pick < 8)
            r.val = $urandom();
        else if (pick < 9)
            r.val = 32'hFFFF_FFFF;
        else
            r.val = 32'hFFFF_FFFE;

        r.pid = 16'($urandom());
        return r;
    endfunction

    task automatic add_row(input action_t act, input logic [7:0] id, input logic [31:0] val,
                           input logic [15:0] pid, input int reps, input bit typed,
                           input status_t st, input logic mb, input logic wv,
                           input logic [15:0] wp);
        dir_row_t row;
        row.req.act          = act;
        row.req.id           = id;
        row.req.val          = val;
        row.req.pid          = pid;
        row.reps             = reps;
        row.typed            = typed;
        row.want.status      = st;
        row.want.must_block  = mb;
        row.want.woken_valid = wv;
        row.want.woken_pid   = wp;
        directed_rows.push_back(row);
    endtask

    // Present one request, hold it until accepted, then record its expected result.
    task automatic drive_request(input sem_req_t r, input bit typed, input res_t want,
                                 output status_t st);
        int   gap;
        res_t pred;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= r.act;
        sem_id     <= r.id;
        init_value <= r.val;
        caller_pid <= r.pid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = sem_apply(r);
        pending_results.push_back(typed ? want : pred);
        st = pred.status;
    endtask

    task automatic check_result();
        res_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d arrived with no request pending", results_seen);
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status || must_block !== want.must_block ||
            woken_valid !== want.woken_valid || woken_pid !== want.woken_pid)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d: exp st=%0d blk=%0d wv=%0d pid=%h %s",
                         results_seen, want.status, want.must_block, want.woken_valid,
                         want.woken_pid,
                         $sformatf("got st=%0d blk=%0d wv=%0d pid=%h",
                                   status, must_block, woken_valid, woken_pid));
        end
    endtask

    // Receiver: check on handshake, then stall at random.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (stall == 0 && $urandom_range(3) == 0)
                stall = idle_len();
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        sem_req_t r;
        status_t  st;
        int       counted;
        int       blk;
        int       bias;
        bit       focus;
        res_t     none;

        none = '0;
        for (int s = 0; s < NUM_SEMS; s++)
        begin
            sem_busy[s]  = 1'b0;
            sem_units[s] = '0;
            wq_head[s]   = 0;
            wq_tail[s]   = 0;
            wq_fill[s]   = 0;
        end

        //      action       id     init_value     pid     reps typed status  blk wv woken
        add_row(ACT_WAIT,    8'd1,   32'd0,        16'h0,     1, 1, ST_NOT_INIT, 0, 0, 16'h0);
        add_row(ACT_POST,    8'd0,   32'd0,        16'h0,     1, 1, ST_BAD_ID,   0, 0, 16'h0);
        add_row(ACT_INIT,    8'd17,  32'hFFFF_FFFF, 16'h0,    1, 1, ST_BAD_ID,   0, 0, 16'h0);
        add_row(ACT_DESTROY, 8'd255, 32'd0,        16'h0,     1, 1, ST_BAD_ID,   0, 0, 16'h0);
        add_row(ACT_DESTROY, 8'd1,   32'd0,        16'h0,     1, 1, ST_NOT_INIT, 0, 0, 16'h0);
        add_row(ACT_INIT,    8'd1,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_INIT,    8'd1,   32'd5,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_WAIT,    8'd1,   32'd0,        16'hFFFF,  1, 1, ST_OK,       1, 0, 16'h0);
        add_row(ACT_WAIT,    8'd1,   32'd0,        16'h0000,  1, 1, ST_OK,       1, 0, 16'h0);
        add_row(ACT_POST,    8'd1,   32'd0,        16'h0,     1, 1, ST_OK,       0, 1, 16'hFFFF);
        add_row(ACT_POST,    8'd1,   32'd0,        16'h0,     1, 1, ST_OK,       0, 1, 16'h0);
        add_row(ACT_POST,    8'd1,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_WAIT,    8'd1,   32'd0,        16'h1111,  1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_INIT,    8'd16,  32'hFFFF_FFFF, 16'h0,    1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_POST,    8'd16,  32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_WAIT,    8'd16,  32'd0,        16'h1234,  1, 0, ST_OK,       0, 0, 16'h0);
        add_row(ACT_POST,    8'd16,  32'd0,        16'h0,     1, 0, ST_OK,       0, 0, 16'h0);
        add_row(ACT_DESTROY, 8'd16,  32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_POST,    8'd16,  32'd0,        16'h0,     1, 1, ST_NOT_INIT, 0, 0, 16'h0);
        add_row(ACT_INIT,    8'd2,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_WAIT,    8'd2,   32'd0,        16'hA000, MAX_WAITERS, 1, ST_OK, 1, 0, 16'h0);
        add_row(ACT_WAIT,    8'd2,   32'd0,        16'h5555,  1, 1, ST_FULL,     0, 0, 16'h0);
        add_row(ACT_POST,    8'd2,   32'd0,        16'h0,     1, 1, ST_OK,       0, 1, 16'hA000);
        add_row(ACT_DESTROY, 8'd2,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_INIT,    8'd2,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_POST,    8'd2,   32'd0,        16'h0,     1, 1, ST_OK,       0, 0, 16'h0);
        add_row(ACT_WAIT,    8'd2,   32'd0,        16'h7E7E,  1, 0, ST_OK,       0, 0, 16'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                r = directed_rows[i].req;
                r.pid = r.pid + 16'(k);
                drive_request(r, directed_rows[i].typed, directed_rows[i].want, st);
            end
        end

        // Random streams in blocks, each with its own mix, id focus and idling.
        counted = 0;
        blk     = 0;
        bias    = 0;
        focus   = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (blk == 0)
            begin
                blk   = BLOCK_LEN;
                bias  = $urandom_range(2);
                focus = $urandom_range(1);
                calm  = ($urandom_range(3) == 0);
            end
            blk--;
            r = random_request(bias, focus);
            drive_request(r, 1'b0, none, st);
            if (st != ST_BAD_ID)
                counted++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[counting_semaphore_table.f]
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/counting_semaphore_table.sv
tb/sv/tb_counting_semaphore_table.sv
